// ----- hw/rtl/llfl_pkg.sv -----
// ----------------------------------------------------------------------------
// llfl_pkg
// Shared types and constants for the linked list cell pool with free list.
// ----------------------------------------------------------------------------
package llfl_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int H_W    = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [H_W-1:0] NULL_H = H_W'(DEPTH);

    typedef enum logic [1:0] {
        MODE_CONS   = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_NEXT   = 2'd3
    } mode_t;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DEPLETED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NULL     = 2'd2;

    // True when the handle names a real cell.
    function automatic logic is_cell(input logic [H_W-1:0] h);
        return h < H_W'(DEPTH);
    endfunction

    // Anything above the last cell counts as null.
    function automatic logic [H_W-1:0] norm_handle(input logic [H_W-1:0] h);
        return is_cell(h) ? h : NULL_H;
    endfunction

endpackage

// ----- hw/rtl/linked_list_free_list_store.sv -----
// ----------------------------------------------------------------------------
// linked_list_free_list_store
// Pool of doubly linked cells with a singly linked free list, run by a small
// sequencer over three single-port cell memories (key, next, prev).
//
//   channel  | handshake       | payload
//   ---------+-----------------+-----------------------------------
//   command  | start / busy    | mode, key, entry
//   result   | done (strobe)   | result_entry, result_key, status
//
// A command transfers when start is high and busy is low. Cons, get and next
// end in S_CONS, S_GET or S_NEXT, delete runs S_DEL_LINK then S_DEL_FREE,
// and a command rejected for a depleted pool or a null handle is answered
// from idle. done pulses for one cycle in the cycle that follows the last
// step, with busy already low. Reset leaves the free list chaining every
// cell in order through per-cell valid bits, so no clearing pass is needed.
// The result side cannot stall.
// ----------------------------------------------------------------------------
module linked_list_free_list_store
    import llfl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              mode,
    input  logic signed [KEY_W-1:0] key,
    input  logic [H_W-1:0]          entry,
    output logic                    done,
    output logic [H_W-1:0]          result_entry,
    output logic signed [KEY_W-1:0] result_key,
    output logic [STAT_W-1:0]       status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONS,
        S_DEL_LINK,
        S_DEL_FREE,
        S_GET,
        S_NEXT
    } state_t;

    state_t                  state_reg, state_next;
    logic [H_W-1:0]          free_head_reg, free_head_next;
    logic [H_W-1:0]          h_reg, h_next;
    logic                    done_reg, done_next;
    logic [H_W-1:0]          res_entry_reg, res_entry_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;

    // cell memories
    logic [KEY_W-1:0] key_mem  [DEPTH];
    logic [H_W-1:0]   next_mem [DEPTH];
    logic [H_W-1:0]   prev_mem [DEPTH];
    logic [DEPTH-1:0] next_vld_reg;

    logic [KEY_W-1:0] key_rd_reg;
    logic [H_W-1:0]   next_rd_reg;
    logic             next_rd_vld_reg;
    logic [IDX_W-1:0] next_rd_idx_reg;
    logic [H_W-1:0]   prev_rd_reg;

    logic             key_re, next_re, prev_re;
    logic [IDX_W-1:0] key_raddr, next_raddr, prev_raddr;
    logic             key_we, next_we, prev_we;
    logic [IDX_W-1:0] key_waddr, next_waddr, prev_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic [H_W-1:0]   next_wdata, prev_wdata;

    logic [H_W-1:0]   in_h;
    logic [H_W-1:0]   next_rd_val;
    logic [IDX_W-1:0] fh_idx;
    logic [IDX_W-1:0] in_idx;

    assign in_h   = norm_handle(entry);
    assign fh_idx = free_head_reg[IDX_W-1:0];
    assign in_idx = in_h[IDX_W-1:0];

    // A next link never written still holds its reset chain value.
    assign next_rd_val = next_rd_vld_reg ? next_rd_reg
                                         : H_W'(next_rd_idx_reg) + H_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        h_next          = h_reg;
        done_next       = 1'b0;
        res_entry_next  = res_entry_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;

        key_re     = 1'b0;
        next_re    = 1'b0;
        prev_re    = 1'b0;
        key_raddr  = in_idx;
        next_raddr = in_idx;
        prev_raddr = in_idx;
        key_we     = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        key_waddr  = fh_idx;
        next_waddr = fh_idx;
        prev_waddr = fh_idx;
        key_wdata  = key;
        next_wdata = h_reg;
        prev_wdata = NULL_H;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    h_next = in_h;
                    if (mode_t'(mode) == MODE_CONS)
                    begin
                        if (!is_cell(free_head_reg))
                        begin
                            done_next       = 1'b1;
                            res_entry_next  = NULL_H;
                            res_key_next    = '0;
                            res_status_next = STATUS_DEPLETED;
                        end
                        else
                        begin
                            // fill the new cell, fetch its free-list successor
                            next_re    = 1'b1;
                            next_raddr = fh_idx;
                            key_we     = 1'b1;
                            key_waddr  = fh_idx;
                            key_wdata  = key;
                            prev_we    = 1'b1;
                            prev_waddr = fh_idx;
                            prev_wdata = NULL_H;
                            state_next = S_CONS;
                        end
                    end
                    else if (!is_cell(in_h))
                    begin
                        done_next       = 1'b1;
                        res_entry_next  = NULL_H;
                        res_key_next    = (mode_t'(mode) == MODE_GET) ? '1 : '0;
                        res_status_next = STATUS_NULL;
                    end
                    else
                    begin
                        unique case (mode_t'(mode))
                            MODE_DELETE:
                            begin
                                prev_re    = 1'b1;
                                next_re    = 1'b1;
                                state_next = S_DEL_LINK;
                            end
                            MODE_GET:
                            begin
                                key_re     = 1'b1;
                                state_next = S_GET;
                            end
                            default:
                            begin
                                next_re    = 1'b1;
                                state_next = S_NEXT;
                            end
                        endcase
                    end
                end
            end

            S_CONS:
            begin
                free_head_next = next_rd_val;
                next_we        = 1'b1;
                next_waddr     = fh_idx;
                next_wdata     = h_reg;
                // point the successor back at the new cell
                if (is_cell(h_reg))
                begin
                    prev_we    = 1'b1;
                    prev_waddr = h_reg[IDX_W-1:0];
                    prev_wdata = free_head_reg;
                end
                done_next       = 1'b1;
                res_entry_next  = free_head_reg;
                res_key_next    = '0;
                res_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end

            S_DEL_LINK:
            begin
                if (is_cell(prev_rd_reg))
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg[IDX_W-1:0];
                    next_wdata = next_rd_val;
                end
                if (is_cell(next_rd_val))
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_val[IDX_W-1:0];
                    prev_wdata = prev_rd_reg;
                end
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE:
            begin
                // push the cell on the free list
                next_we         = 1'b1;
                next_waddr      = h_reg[IDX_W-1:0];
                next_wdata      = free_head_reg;
                free_head_next  = h_reg;
                done_next       = 1'b1;
                res_entry_next  = NULL_H;
                res_key_next    = '0;
                res_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end

            S_GET:
            begin
                done_next       = 1'b1;
                res_entry_next  = NULL_H;
                res_key_next    = key_rd_reg;
                res_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end

            S_NEXT:
            begin
                done_next       = 1'b1;
                res_entry_next  = next_rd_val;
                res_key_next    = '0;
                res_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg          <= h_next;
        res_entry_reg  <= res_entry_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg <= '0;
        end
        else if (next_we)
        begin
            next_vld_reg[next_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[key_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (next_re)
        begin
            next_rd_reg     <= next_mem[next_raddr];
            next_rd_vld_reg <= next_vld_reg[next_raddr];
            next_rd_idx_reg <= next_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re)
        begin
            prev_rd_reg <= prev_mem[prev_raddr];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_entry = res_entry_reg;
    assign result_key   = res_key_reg;
    assign status       = res_status_reg;

endmodule

// ----- hw/rtl/llfl_checker.sv -----
// ----------------------------------------------------------------------------
// llfl_checker
// Port-level checks on the command and result sides of the cell pool.
// ----------------------------------------------------------------------------
module llfl_checker
    import llfl_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic [H_W-1:0]          result_entry,
    input logic signed [KEY_W-1:0] result_key,
    input logic [STAT_W-1:0]       status
);

    // a result only shows while the sequencer is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // busy only rises right after a command transfer
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // every multi-cycle command ends with a result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_depleted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_DEPLETED) |-> (result_entry == NULL_H && result_key == '0))
        else $error("depleted result carries data");

    a_null_target: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_NULL) |-> result_entry == NULL_H)
        else $error("null target returned a handle");

endmodule

bind linked_list_free_list_store llfl_checker u_llfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_entry (result_entry),
    .result_key   (result_key),
    .status       (status)
);
